// ===== sv/tksd_pkg.sv =====
// Package for the terminal key sequence decoder.
// Holds the parse state and key code types, byte constants and the plain byte map.
// No dependencies.
package tksd_pkg;

  localparam int unsigned CountW = 20;
  localparam logic [CountW-1:0] TimeoutReset = 20'd50000;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2,
    MODE_CSI3 = 2'd3
  } parse_mode_t;

  typedef enum logic [4:0] {
    K_NONE  = 5'd0,
    K_ESC   = 5'd1,
    K_UP    = 5'd2,
    K_DOWN  = 5'd3,
    K_RIGHT = 5'd4,
    K_LEFT  = 5'd5,
    K_DEL   = 5'd6,
    K_ENTER = 5'd7,
    K_BKSP  = 5'd8,
    K_TAB   = 5'd9,
    K_SLASH = 5'd10,
    K_J     = 5'd11,
    K_K     = 5'd12,
    K_H     = 5'd13,
    K_L     = 5'd14,
    K_Q     = 5'd15,
    K_LG    = 5'd16,
    K_UG    = 5'd17,
    K_CHAR  = 5'd18
  } key_code_t;

  typedef struct packed {
    key_code_t   code;
    logic [7:0]  chr;
  } key_t;

  localparam logic [7:0] B_CTRL_C = 8'd3;
  localparam logic [7:0] B_BS     = 8'd8;
  localparam logic [7:0] B_TAB    = 8'd9;
  localparam logic [7:0] B_LF     = 8'd10;
  localparam logic [7:0] B_CR     = 8'd13;
  localparam logic [7:0] B_ESC    = 8'd27;
  localparam logic [7:0] B_DEL    = 8'd127;
  localparam logic [7:0] B_LBRACK = 8'h5B;
  localparam logic [7:0] B_TILDE  = 8'h7E;
  localparam logic [7:0] B_THREE  = 8'h33;
  localparam logic [7:0] B_UA     = 8'h41;
  localparam logic [7:0] B_UB     = 8'h42;
  localparam logic [7:0] B_UC     = 8'h43;
  localparam logic [7:0] B_UD     = 8'h44;
  localparam logic [7:0] B_SLASH  = 8'h2F;
  localparam logic [7:0] B_LJ     = 8'h6A;
  localparam logic [7:0] B_LK     = 8'h6B;
  localparam logic [7:0] B_LH     = 8'h68;
  localparam logic [7:0] B_LL     = 8'h6C;
  localparam logic [7:0] B_LQ     = 8'h71;
  localparam logic [7:0] B_LG     = 8'h67;
  localparam logic [7:0] B_UG     = 8'h47;

  function automatic key_t plain_key(input logic [7:0] b);
    key_t k;
    k.chr = 8'd0;
    case (b)
      B_CTRL_C:     k.code = K_ESC;
      B_CR, B_LF:   k.code = K_ENTER;
      B_DEL, B_BS:  k.code = K_BKSP;
      B_TAB:        k.code = K_TAB;
      B_SLASH:      k.code = K_SLASH;
      B_LJ:         k.code = K_J;
      B_LK:         k.code = K_K;
      B_LH:         k.code = K_H;
      B_LL:         k.code = K_L;
      B_LQ:         k.code = K_Q;
      B_LG:         k.code = K_LG;
      B_UG:         k.code = K_UG;
      default: begin
        k.code = K_CHAR;
        k.chr  = b;
      end
    endcase
    return k;
  endfunction

endpackage

// ===== sv/terminal_key_sequence_decoder.sv =====
// Terminal key sequence decoder: parse state machine and two-entry result buffer.
// Depends on tksd_pkg.
//
// Usage:
//   in_*  : one transfer per received byte or time tick. in_tuser = 1 marks a tick,
//           in_tdata carries the byte (ignored for ticks).
//   out_* : one transfer per decoded key; out_tuser holds the key code, out_tdata
//           the character for character keys, zero otherwise.
//   cfg_* : escape timeout in ticks; always ready, write only while idle.
// Each result is registered in the result buffer before it appears on out_tvalid.
// Throughput: one input transfer per cycle while in_tready is high; the decode
//   is a single pass of logic between the input handshake and the result register.
// Escape prefixes, the [ and 3 bytes of a CSI sequence and most ticks give no result.
// Reset: parser idle, wait count zero, timeout 50000, buffer empty.
// Stall: a main result register plus one skid entry; in_tready drops only
//   while the skid entry is occupied, so the input side keeps moving until the
//   skid entry takes a result during a receiver stall.
module terminal_key_sequence_decoder
  import tksd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tuser,   // [0] func (1 = tick)
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] key_char
  output logic [4:0]        out_tuser,  // [4:0] key_code
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data
);

  parse_mode_t       mode_r, mode_nxt;
  logic [CountW-1:0] wait_count_r, wait_count_nxt;
  logic [CountW-1:0] timeout_r;
  logic [CountW-1:0] cnt_inc;
  logic              timed_out;
  logic              acc;
  logic              res_valid;
  key_t              res;
  logic              main_valid_r, skid_valid_r;
  key_t              main_r, skid_r;
  logic              push, pop;

  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cnt_inc   = wait_count_r + {{(CountW-1){1'b0}}, 1'b1};
  assign timed_out = (cnt_inc >= timeout_r) || (cnt_inc == '0);

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    wait_count_nxt = wait_count_r;
    if (in_tuser) begin
      if (mode_r == MODE_ESC) begin
        if (timed_out) begin
          mode_nxt       = MODE_IDLE;
          wait_count_nxt = '0;
        end else begin
          wait_count_nxt = cnt_inc;
        end
      end
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (in_tdata == B_ESC) begin
            mode_nxt       = MODE_ESC;
            wait_count_nxt = '0;
          end
        end
        MODE_ESC: begin
          wait_count_nxt = '0;
          mode_nxt       = (in_tdata == B_LBRACK) ? MODE_CSI : MODE_IDLE;
        end
        MODE_CSI: begin
          mode_nxt = (in_tdata == B_THREE) ? MODE_CSI3 : MODE_IDLE;
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res.code  = K_NONE;
    res.chr   = 8'd0;
    if (in_tuser) begin
      if ((mode_r == MODE_ESC) && timed_out) begin
        res_valid = 1'b1;
        res.code  = K_ESC;
      end
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (in_tdata != B_ESC) begin
            res_valid = 1'b1;
            res       = plain_key(in_tdata);
          end
        end
        MODE_ESC: begin
          if (in_tdata != B_LBRACK) begin
            res_valid = 1'b1;
            res.code  = K_ESC;
          end
        end
        MODE_CSI: begin
          if (in_tdata != B_THREE) begin
            res_valid = 1'b1;
            case (in_tdata)
              B_UA:    res.code = K_UP;
              B_UB:    res.code = K_DOWN;
              B_UC:    res.code = K_RIGHT;
              B_UD:    res.code = K_LEFT;
              default: res.code = K_NONE;
            endcase
          end
        end
        default: begin
          res_valid = 1'b1;
          res.code  = (in_tdata == B_TILDE) ? K_DEL : K_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      wait_count_r <= '0;
      timeout_r    <= TimeoutReset;
    end else begin
      if (acc) begin
        mode_r       <= mode_nxt;
        wait_count_r <= wait_count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // result buffer
  assign push = acc && res_valid;
  assign pop  = main_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = main_valid_r;
  assign out_tuser  = main_r.code;
  assign out_tdata  = main_r.chr;

`ifndef NO_ASSERTIONS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty main register");

  a_count_only_in_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_ESC) |-> (wait_count_r == '0))
    else $error("wait count nonzero outside escape wait");

  a_esc_byte_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tuser && (mode_r == MODE_IDLE) && (in_tdata == B_ESC))
      |=> (mode_r == MODE_ESC))
    else $error("escape byte did not start escape wait");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid)
    else $error("result pushed but output not valid");
`endif

endmodule
